// ===== design/pgn_pkg.sv =====
// ----------------------------------------------------------------------------
// Perlin noise package
// Shared constants and the gradient sine table for the 2D noise unit.
// ----------------------------------------------------------------------------
package pgn_pkg;

  localparam int FracBits  = 16;
  localparam int AngleBits = 10;
  localparam int AngleN    = 1 << AngleBits;

  // The table covers one quarter turn; the two top angle bits pick the quadrant.
  localparam int QuarterBits = AngleBits - 2;
  localparam int QuarterN    = 1 << QuarterBits;

  localparam logic [31:0] HashK1 = 32'd3284157443;
  localparam logic [31:0] HashK2 = 32'd1911520717;
  localparam logic [31:0] HashK3 = 32'd2048419325;

  localparam longint SinA = 25719;
  localparam longint SinB = 10477;
  localparam longint SinC = 1142;

  typedef logic [QuarterN-1:0][15:0] quarter_tab_t;

  // Sine of a quarter-turn position, Q14 in and out.
  function automatic longint quarter_sine(input longint x);
    longint x2;
    longint t;
    x2 = (x * x) >>> 14;
    t = (SinC * x2) >>> 14;
    t = SinB - t;
    t = (t * x2) >>> 14;
    t = SinA - t;
    return (t * x) >>> 14;
  endfunction

  // Quarter-wave sine at each table step, evaluated at elaboration.
  function automatic quarter_tab_t build_quarter_tab();
    quarter_tab_t tab;
    for (int k = 0; k < QuarterN; k++) begin
      tab[k] = 16'(quarter_sine(longint'(k) << (16 - AngleBits)));
    end
    return tab;
  endfunction

  localparam quarter_tab_t QuarterTab = build_quarter_tab();

  // Sine for a quadrant and a step within it, Q1.14. In odd quadrants the
  // table is read backward; the quarter-turn point itself is full scale.
  function automatic logic signed [15:0] fold_sine(input logic [1:0] q,
                                                   input logic [QuarterBits-1:0] k);
    logic [QuarterBits-1:0] m;
    logic signed [15:0] s;
    m = -k;
    if (!q[0]) s = signed'(QuarterTab[k]);
    else if (k == '0) s = 16'sd16384;
    else s = signed'(QuarterTab[m]);
    if (q[1]) s = -s;
    return s;
  endfunction

  // Gradient x component (sine) for an angle index.
  function automatic logic signed [15:0] grad_sin(input logic [AngleBits-1:0] idx);
    return fold_sine(idx[AngleBits-1 -: 2], idx[QuarterBits-1:0]);
  endfunction

  // Gradient z component (cosine) for an angle index.
  function automatic logic signed [15:0] grad_cos(input logic [AngleBits-1:0] idx);
    return fold_sine(idx[AngleBits-1 -: 2] + 2'd1, idx[QuarterBits-1:0]);
  endfunction

endpackage

// ===== design/perlin_gradient_noise_2d_unit.sv =====
// Throughput: one point per cycle.
// The four corner hashes run side by side in five-stage pipelines and the
// blends take four further stages; busy is always low.
// Reset clears the valid bits only; the data pipeline registers are not reset.
// ----------------------------------------------------------------------------
// Perlin gradient noise 2D unit
// Pipelined 2D hashed-gradient noise, signed Q16.16 in, signed Q2.14 out.
// ----------------------------------------------------------------------------
module perlin_gradient_noise_2d_unit
  import pgn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_z,
  output logic               result_valid,
  output logic signed [15:0] noise_value
);

  localparam int Lat = 9;

  logic [Lat-1:0] vld;
  logic           take;
  logic [31:0]    x0, z0, x1, z1;
  logic [15:0]    wxf, wzf;
  logic signed [17:0] fx0, fz0, fx1, fz1;
  logic signed [35:0] d00, d10, d01, d11;

  assign busy = 1'b0;
  assign take = start;

  // Cell corners and fractions.
  assign x0 = 32'(coord_x >>> FracBits);
  assign z0 = 32'(coord_z >>> FracBits);
  assign x1 = x0 + 32'd1;
  assign z1 = z0 + 32'd1;
  assign wxf = 16'({coord_x[FracBits-1:0], 16'd0} >> FracBits);
  assign wzf = 16'({coord_z[FracBits-1:0], 16'd0} >> FracBits);
  assign fx0 = $signed({2'b00, wxf});
  assign fz0 = $signed({2'b00, wzf});
  assign fx1 = fx0 - 18'sd65536;
  assign fz1 = fz0 - 18'sd65536;

  pgn_corner u_c00 (.clk, .cx(x0), .cz(z0), .fx(fx0), .fz(fz0), .dot(d00));
  pgn_corner u_c10 (.clk, .cx(x1), .cz(z0), .fx(fx1), .fz(fz0), .dot(d10));
  pgn_corner u_c01 (.clk, .cx(x0), .cz(z1), .fx(fx0), .fz(fz1), .dot(d01));
  pgn_corner u_c11 (.clk, .cx(x1), .cz(z1), .fx(fx1), .fz(fz1), .dot(d11));

  // Fade pipeline: one multiply per stage, five stages, both axes.
  logic signed [21:0] tx1, tz1;
  logic signed [37:0] tx2, tz2, tx3, tz3, tx4, tz4, tx5, tz5;
  logic [15:0] w1x, w1z, w2x, w2z, w3x, w3z, w4x, w4z;

  always_ff @(posedge clk) begin
    tx1 <= signed'({6'd0, wxf}) * 22'sd6 - 22'sd983040;
    tz1 <= signed'({6'd0, wzf}) * 22'sd6 - 22'sd983040;
    w1x <= wxf;
    w1z <= wzf;
    tx2 <= ((38'(tx1) * signed'({22'd0, w1x})) >>> 16) + 38'sd655360;
    tz2 <= ((38'(tz1) * signed'({22'd0, w1z})) >>> 16) + 38'sd655360;
    w2x <= w1x;
    w2z <= w1z;
    tx3 <= (tx2 * signed'({22'd0, w2x})) >>> 16;
    tz3 <= (tz2 * signed'({22'd0, w2z})) >>> 16;
    w3x <= w2x;
    w3z <= w2z;
    tx4 <= (tx3 * signed'({22'd0, w3x})) >>> 16;
    tz4 <= (tz3 * signed'({22'd0, w3z})) >>> 16;
    w4x <= w3x;
    w4z <= w3z;
    tx5 <= (tx4 * signed'({22'd0, w4x})) >>> 16;
    tz5 <= (tz4 * signed'({22'd0, w4z})) >>> 16;
  end

  // Delay the fades so each meets its blend stage.
  logic signed [37:0] tx6, tz6, tz7, tz8;
  always_ff @(posedge clk) begin
    tx6 <= tx5;
    tz6 <= tz5;
    tz7 <= tz6;
    tz8 <= tz7;
  end

  // Blend stages.
  logic signed [37:0] dlo6, dhi6, a0lo6, a0hi6, lo7, hi7, dv8, lo8;
  logic signed [17:0] fxs;
  logic signed [17:0] fzs;
  logic signed [57:0] plo, phi, pv;
  logic signed [37:0] v9;
  logic signed [37:0] r9;
  assign fxs = 18'(tx6);
  assign fzs = 18'(tz8);

  always_ff @(posedge clk) begin
    a0lo6 <= 38'(d00);
    a0hi6 <= 38'(d01);
    dlo6  <= 38'(d10) - 38'(d00);
    dhi6  <= 38'(d11) - 38'(d01);
  end

  assign plo = 58'(dlo6) * 58'(fxs);
  assign phi = 58'(dhi6) * 58'(fxs);

  always_ff @(posedge clk) begin
    lo7 <= a0lo6 + 38'(plo >>> 16);
    hi7 <= a0hi6 + 38'(phi >>> 16);
  end

  always_ff @(posedge clk) begin
    lo8 <= lo7;
    dv8 <= hi7 - lo7;
  end

  assign pv = 58'(dv8) * 58'(fzs);

  always_ff @(posedge clk) begin
    v9 <= lo8 + 38'(pv >>> 16);
  end

  // Round and saturate.
  assign r9 = (v9 + 38'sd32768) >>> 16;
  assign noise_value = (r9 > 38'sd32767) ? 16'sh7fff :
                       (r9 < -38'sd32768) ? 16'sh8000 : 16'(r9);

  // Valid bits; timing must line up with the data stages above.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Lat-2:0], take};
    end
  end

  assign result_valid = vld[Lat-1];

`ifndef SYNTH
  a_busy_low: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    start ##9 1 |-> result_valid) else $error("result missing");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start, 9)) else $error("spurious result");
`endif

endmodule

// ===== design/pgn_corner.sv =====
// ----------------------------------------------------------------------------
// Corner gradient dot
// Hashes one cell corner over three registered multiply stages, looks up the
// gradient and forms the Q.30 dot product with the corner offsets.
// One corner per cycle.
// ----------------------------------------------------------------------------
module pgn_corner
  import pgn_pkg::*;
(
  input  logic               clk,
  input  logic [31:0]        cx,
  input  logic [31:0]        cz,
  input  logic signed [17:0] fx,
  input  logic signed [17:0] fz,
  output logic signed [35:0] dot
);

  logic [31:0] a1, b1;
  logic signed [17:0] fx1, fz1, fx2, fz2, fx3, fz3, fx4, fz4;
  logic [31:0] a2, b2;
  logic [AngleBits-1:0] idx3;
  logic signed [15:0] gx4, gz4;
  logic signed [35:0] px5, pz5;
  logic [31:0] a3_in;

  // First hash multiply.
  always_ff @(posedge clk) begin
    a1  <= cx * HashK1;
    b1  <= cz;
    fx1 <= fx;
    fz1 <= fz;
  end

  // Second hash multiply.
  always_ff @(posedge clk) begin
    b2  <= (b1 ^ {a1[15:0], a1[31:16]}) * HashK2;
    a2  <= a1;
    fx2 <= fx1;
    fz2 <= fz1;
  end

  // Third hash multiply keeps only the angle bits.
  assign a3_in = (a2 ^ {b2[15:0], b2[31:16]}) * HashK3;

  always_ff @(posedge clk) begin
    idx3 <= a3_in[31 -: AngleBits];
    fx3  <= fx2;
    fz3  <= fz2;
  end

  // Gradient table lookup.
  always_ff @(posedge clk) begin
    gx4 <= grad_sin(idx3);
    gz4 <= grad_cos(idx3);
    fx4 <= fx3;
    fz4 <= fz3;
  end

  // Component products, then their sum.
  always_ff @(posedge clk) begin
    px5 <= 36'(fx4) * 36'(gx4);
    pz5 <= 36'(fz4) * 36'(gz4);
  end

  assign dot = px5 + pz5;

endmodule
